/* rtl/fixed_point_alu_core_assert.svh */
// Assertion macros for the fixed-point ALU core.
// No dependencies. Define ASSERT_OFF to compile them out.
`ifndef FIXED_POINT_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_ALU_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define FPA_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("fpa assertion failed");
`define FPA_ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("fpa assertion failed");
`else
`define FPA_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define FPA_ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`endif
`endif

/* rtl/fpa_pkg.sv */
// Package for the fixed-point ALU core: opcodes and the per-beat sideband type.
// No dependencies.
`default_nettype none
package fpa_pkg;
   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_CMP = 4'd4;
   localparam logic [3:0] OP_MIN = 4'd5;
   localparam logic [3:0] OP_MAX = 4'd6;
   localparam logic [3:0] OP_INC = 4'd7;
   localparam logic [3:0] OP_DEC = 4'd8;
   localparam logic [3:0] OP_INT = 4'd9;

   typedef struct packed {
      logic        valid;
      logic [3:0]  op;
      logic [31:0] res;
      logic        lt;
      logic        eq;
      logic        gt;
      logic        dz;
      logic        neg;
   } side_type;
endpackage
`default_nettype wire

/* rtl/fixed_point_alu_core.sv */
// Fixed-point ALU core: input stage, a chain of division cells, output register.
// Depends on fpa_pkg, fpa_div_cell and fixed_point_alu_core_assert.svh.
//
// Usage: one request beat (req_type, req_operand_a, req_operand_b) gives one
// response beat. Every operation travels the same pipeline so responses come
// back in request order. The pipeline holds one input stage with the multiplier
// product, one division cell per quotient bit, and the output register.
// Throughput is one beat per cycle while rsp_stall holds no pending response;
// the cell chain sets the depth, the 32x32 multiplier the input stage.
// Reset clears all valid bits; payload registers are not reset.
// When rsp_stall holds a pending response, the whole pipeline freezes and
// req_stall is raised in the same cycle; it drops as soon as the response is
// taken, so a new request can enter while the response register turns over.
// Operands use their low WORD_BITS bits as two's complement and results are
// sign-extended to 32 bits.
`default_nettype none
`include "fixed_point_alu_core_assert.svh"
module fixed_point_alu_core #(
   parameter int FRAC_BITS = 8,
   parameter int WORD_BITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_type,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_result_value,
   output logic                    rsp_a_less,
   output logic                    rsp_a_equal,
   output logic                    rsp_a_greater,
   output logic                    rsp_divide_by_zero
);
   import fpa_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int NQ = W + F;

   function automatic logic [31:0] sext(input logic [W-1:0] x);
      return 32'(signed'(x));
   endfunction

   logic adv;
   logic signed [W-1:0] a, b;
   logic [W-1:0]        ma, mb;
   logic [31:0]         res0_in;
   side_type            side0_ff, side0_in;
   side_type            side_head;
   logic signed [2*W-1:0] prod_ff;
   logic [NQ-1:0]       dq0_ff;
   logic [W-1:0]        mb0_ff;

   logic [W-1:0]  rem_c [0:NQ];
   logic [NQ-1:0] dq_c  [0:NQ];
   logic [W-1:0]  mb_c  [0:NQ];
   side_type      side_c [0:NQ];

   logic [W-1:0]  q;
   logic [31:0]   out_res_in;
   side_type      out_ff;
   logic [2*W-1:0] prod_sh;
   logic [2:0]    cmp_flags;
   logic          cmp_hit;

   assign adv       = ~(out_ff.valid & rsp_stall);
   assign req_stall = ~adv;

   always_comb begin
      a  = req_operand_a[W-1:0];
      b  = req_operand_b[W-1:0];
      ma = a[W-1] ? (~a + 1'b1) : a;
      mb = b[W-1] ? (~b + 1'b1) : b;
      res0_in = '0;
      case (req_type)
         OP_ADD:  res0_in = sext(a + b);
         OP_SUB:  res0_in = sext(a - b);
         OP_MIN:  res0_in = sext((a > b) ? b : a);
         OP_MAX:  res0_in = sext((a < b) ? b : a);
         OP_INC:  res0_in = sext(a + 1'b1);
         OP_DEC:  res0_in = sext(a - 1'b1);
         OP_INT:  res0_in = sext(a >>> F);
         default: res0_in = '0;
      endcase
      side0_in.valid = req_valid;
      side0_in.op    = req_type;
      side0_in.res   = res0_in;
      side0_in.lt    = (req_type == OP_CMP) && (a < b);
      side0_in.eq    = (req_type == OP_CMP) && (a == b);
      side0_in.gt    = (req_type == OP_CMP) && (a > b);
      side0_in.dz    = (req_type == OP_DIV) && (b == '0);
      side0_in.neg   = a[W-1] ^ b[W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side0_ff.valid <= 1'b0;
      end else if (adv) begin
         side0_ff <= side0_in;
      end
      if (adv) begin
         prod_ff <= a * b;
         dq0_ff  <= NQ'(ma) << F;
         mb0_ff  <= mb;
      end
   end

   always_comb begin
      prod_sh   = prod_ff >>> F;
      side_head = side0_ff;
      if (side0_ff.op == OP_MUL) begin
         side_head.res = sext(prod_sh[W-1:0]);
      end
   end

   assign side_c[0] = side_head;
   assign rem_c[0]  = '0;
   assign dq_c[0]   = dq0_ff;
   assign mb_c[0]   = mb0_ff;

   for (genvar i = 0; i < NQ; i++) begin : g_cell
      fpa_div_cell #(.W(W), .F(F)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .rem_in   (rem_c[i]),
         .dq_in    (dq_c[i]),
         .mb_in    (mb_c[i]),
         .side_in  (side_c[i]),
         .rem_out  (rem_c[i+1]),
         .dq_out   (dq_c[i+1]),
         .mb_out   (mb_c[i+1]),
         .side_out (side_c[i+1])
      );
   end

   always_comb begin
      q = side_c[NQ].neg ? (~dq_c[NQ][W-1:0] + 1'b1) : dq_c[NQ][W-1:0];
      out_res_in = side_c[NQ].res;
      if (side_c[NQ].op == OP_DIV) begin
         out_res_in = side_c[NQ].dz ? '0 : sext(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ff.valid <= side_c[NQ].valid;
      end
      if (adv) begin
         out_ff.op  <= side_c[NQ].op;
         out_ff.res <= out_res_in;
         out_ff.lt  <= side_c[NQ].lt;
         out_ff.eq  <= side_c[NQ].eq;
         out_ff.gt  <= side_c[NQ].gt;
         out_ff.dz  <= side_c[NQ].dz;
         out_ff.neg <= side_c[NQ].neg;
      end
   end

   assign rsp_valid          = out_ff.valid;
   assign rsp_result_value   = out_ff.res;
   assign rsp_a_less         = out_ff.lt;
   assign rsp_a_equal        = out_ff.eq;
   assign rsp_a_greater      = out_ff.gt;
   assign rsp_divide_by_zero = out_ff.dz;

   assign cmp_flags = {rsp_a_less, rsp_a_equal, rsp_a_greater};
   assign cmp_hit   = rsp_valid && (|cmp_flags);

   `FPA_ASSERT_IMPLIES(a_cmp_onehot, clock, reset, rsp_valid, $onehot0(cmp_flags))
   `FPA_ASSERT_IMPLIES(a_dz_zero, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_result_value == 0)
   `FPA_ASSERT_IMPLIES(a_flags_op, clock, reset, cmp_hit, out_ff.op == OP_CMP)
   `FPA_ASSERT_IMPLIES(a_flags_res, clock, reset, cmp_hit, rsp_result_value == 0)
endmodule
`default_nettype wire

/* rtl/fpa_div_cell.sv */
// One restoring-division cell: produces one quotient bit per beat.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div_cell #(
   parameter int W = 32,
   parameter int F = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic [W-1:0]       rem_in,
   input  wire logic [W+F-1:0]     dq_in,
   input  wire logic [W-1:0]       mb_in,
   input  wire fpa_pkg::side_type  side_in,
   output logic [W-1:0]            rem_out,
   output logic [W+F-1:0]          dq_out,
   output logic [W-1:0]            mb_out,
   output fpa_pkg::side_type       side_out
);
   import fpa_pkg::*;

   logic [W:0]     sh;
   logic [W:0]     diff;
   logic           ge;
   logic [W-1:0]   rem_ff, rem_in_n;
   logic [W+F-1:0] dq_ff;
   logic [W-1:0]   mb_ff;
   side_type       side_ff;

   always_comb begin
      sh       = {rem_in, dq_in[W+F-1]};
      diff     = sh - {1'b0, mb_in};
      ge       = ~diff[W];
      rem_in_n = ge ? diff[W-1:0] : sh[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff <= side_in;
      end
      if (en) begin
         rem_ff <= rem_in_n;
         dq_ff  <= {dq_in[W+F-2:0], ge};
         mb_ff  <= mb_in;
      end
   end

   assign rem_out  = rem_ff;
   assign dq_out   = dq_ff;
   assign mb_out   = mb_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire
